>>> src/sat_pkg.sv
`default_nettype none

package sat_pkg;

   // request kinds carried in req_tuser
   typedef enum logic [1:0] {
      REQ_CLEAR  = 2'd0,
      REQ_UPDATE = 2'd1,
      REQ_READ   = 2'd2,
      REQ_NONE   = 2'd3
   } req_kind_type;

   localparam int VALUE_W = 24;
   localparam int POINT_W = 12;
   localparam int INDEX_W = 6;

   localparam logic signed [VALUE_W-1:0] FLOOR_RESET = -24'sd256000;

   // one table word: valid mark, point of the maximum, the maximum
   typedef struct packed {
      logic                      valid;
      logic [POINT_W-1:0]        point;
      logic signed [VALUE_W-1:0] value;
   } entry_type;

endpackage

`default_nettype wire

>>> src/segmented_argmax_table_core.sv
// Scatter argmax pooling table.
// The req channel carries one request per transaction: req_tuser gives the kind
// (clear table, sample update, read entry), req_tdata the channel, cluster,
// point number and sample value. Only a read returns a transaction on the rsp
// channel: the winning point, winning value and, in rsp_tuser, the beat_floor
// flag. The csr channel writes the floor value; it is always ready.
// The table sits in one synchronous RAM of CHANNELS*CLUSTERS words. A request
// reads its entry in the cycle it is accepted and compares and writes back in
// the next one; a write that lands on the same entry in that cycle is
// forwarded. Updates and reads are taken one per cycle while req_tready is
// high; a read result goes from stage 1 into the result register behind rsp.
// A clear request walks the RAM one word per cycle, dropping every valid mark;
// req_tready is low during the walk. The same walk runs right after reset.
// The result register holds a read result until rsp_tready; while it is full
// and a second read waits behind it, req_tready goes low.
`default_nettype none

module segmented_argmax_table_core #(
   parameter int CHANNELS = 64,
   parameter int CLUSTERS = 64,
   parameter int POINTS   = 4096
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // channel [5:0], cluster [11:6], point_number [23:12], sample_value [47:24]
   input  wire logic [47:0] req_tdata,
   // req_type [1:0]
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // winning_point [11:0], winning_value [35:12], zero fill [39:36]
   output logic [39:0]      rsp_tdata,
   // beat_floor [0]
   output logic [0:0]       rsp_tuser,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   // floor_value [23:0]
   input  wire logic [23:0] csr_data
);
   import sat_pkg::*;

   localparam int ENTRIES = CHANNELS * CLUSTERS;
   localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   entry_type mem [ENTRIES];

   logic signed [VALUE_W-1:0] floor_ff;

   logic                sweep_ff, sweep_in;
   logic [ADDR_W-1:0]   sweep_cnt_ff, sweep_cnt_in;

   logic                s1_v_ff, s1_v_in;
   req_kind_type        s1_kind_ff;
   logic                s1_in_range_ff;
   logic                s1_pt_ok_ff;
   logic [ADDR_W-1:0]   s1_addr_ff;
   logic [POINT_W-1:0]  s1_point_ff;
   logic signed [VALUE_W-1:0] s1_value_ff;
   logic                s1_fwd_ff;
   entry_type           s1_fwd_word_ff;
   entry_type           rd_word_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [POINT_W-1:0]  rsp_point_ff;
   logic signed [VALUE_W-1:0] rsp_value_ff;
   logic                rsp_beat_ff;

   logic [INDEX_W-1:0]  req_channel, req_cluster;
   logic [POINT_W-1:0]  req_point;
   logic signed [VALUE_W-1:0] req_value;
   req_kind_type        req_kind;
   logic [ADDR_W-1:0]   req_addr;
   logic                req_in_range, req_pt_ok;
   logic                accept, s1_stall;

   entry_type           cur_word, wr_word;
   logic signed [VALUE_W-1:0] cur_value;
   logic                upd_win, wr_en;
   logic [ADDR_W-1:0]   wr_addr;

   assign req_channel = req_tdata[5:0];
   assign req_cluster = req_tdata[11:6];
   assign req_point   = req_tdata[23:12];
   assign req_value   = req_tdata[47:24];
   assign req_kind    = req_kind_type'(req_tuser);

   assign req_addr = ADDR_W'(ADDR_W'(req_channel) * ADDR_W'(CLUSTERS) + ADDR_W'(req_cluster));
   assign req_in_range = (32'(req_channel) < CHANNELS) && (32'(req_cluster) < CLUSTERS);
   assign req_pt_ok    = 32'(req_point) < POINTS;

   // a read waiting in stage 1 needs the result register free
   assign s1_stall   = s1_v_ff && (s1_kind_ff == REQ_READ) && rsp_valid_ff && !rsp_tready;
   assign req_tready = !sweep_ff && !s1_stall;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // stage 1: compare against the stored maximum or the floor
   always_comb begin
      cur_word  = s1_fwd_ff ? s1_fwd_word_ff : rd_word_ff;
      cur_value = cur_word.valid ? cur_word.value : floor_ff;
      upd_win   = s1_v_ff && (s1_kind_ff == REQ_UPDATE) && s1_in_range_ff && s1_pt_ok_ff
                  && (s1_value_ff > cur_value);
      wr_en     = sweep_ff || upd_win;
      wr_addr   = sweep_ff ? sweep_cnt_ff : s1_addr_ff;
      if (sweep_ff) begin
         wr_word = '0;
      end else begin
         wr_word.valid = 1'b1;
         wr_word.point = s1_point_ff;
         wr_word.value = s1_value_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_word;
      end
      if (accept) begin
         rd_word_ff <= mem[req_addr];
      end
   end

   // sweep control
   always_comb begin
      sweep_in     = sweep_ff;
      sweep_cnt_in = sweep_cnt_ff;
      if (sweep_ff) begin
         sweep_cnt_in = sweep_cnt_ff + ADDR_W'(1);
         if (sweep_cnt_ff == ADDR_W'(ENTRIES - 1)) begin
            sweep_in     = 1'b0;
            sweep_cnt_in = '0;
         end
      end else if (accept && req_kind == REQ_CLEAR) begin
         sweep_in     = 1'b1;
         sweep_cnt_in = '0;
      end
   end

   always_comb begin
      s1_v_in = s1_stall ? s1_v_ff : accept;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_v_ff && (s1_kind_ff == REQ_READ) && !s1_stall) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         floor_ff     <= FLOOR_RESET;
         sweep_ff     <= 1'b1;
         sweep_cnt_ff <= '0;
         s1_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            floor_ff <= csr_data;
         end
         sweep_ff     <= sweep_in;
         sweep_cnt_ff <= sweep_cnt_in;
         s1_v_ff      <= s1_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_kind_ff     <= req_kind;
         s1_in_range_ff <= req_in_range;
         s1_pt_ok_ff    <= req_pt_ok;
         s1_addr_ff     <= req_addr;
         s1_point_ff    <= req_point;
         s1_value_ff    <= req_value;
         // a write to the same word at this edge is missed by the ram read
         s1_fwd_ff      <= wr_en && (wr_addr == req_addr);
         s1_fwd_word_ff <= wr_word;
      end
      if (s1_v_ff && (s1_kind_ff == REQ_READ) && !s1_stall) begin
         if (s1_in_range_ff && cur_word.valid) begin
            rsp_point_ff <= cur_word.point;
            rsp_value_ff <= cur_word.value;
            rsp_beat_ff  <= 1'b1;
         end else begin
            rsp_point_ff <= '0;
            rsp_value_ff <= floor_ff;
            rsp_beat_ff  <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_value_ff, rsp_point_ff};
   assign rsp_tuser  = rsp_beat_ff;

endmodule

`default_nettype wire
